// ===== rtl/response_stream_deframer_macros.svh =====
// Assertion helpers shared by the deframer RTL.
`ifndef RESPONSE_STREAM_DEFRAMER_MACROS_SVH
`define RESPONSE_STREAM_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsd_pkg.sv =====
package rsd_pkg;

    // Frame type codes carried in the leading byte
    localparam logic [7:0] TYPE_TILE = 8'h81;
    localparam logic [7:0] TYPE_ELEV = 8'h82;
    localparam logic [7:0] TYPE_META = 8'h83;
    localparam logic [7:0] TYPE_ERR  = 8'hFF;

    // Header byte counts after the type byte
    localparam logic [4:0] HDR_LEN_TILE = 5'd16;
    localparam logic [4:0] HDR_LEN_ELEV = 5'd24;
    localparam logic [4:0] HDR_LEN_META = 5'd4;
    localparam logic [4:0] HDR_LEN_ERR  = 5'd5;

    // Output bus widths
    localparam int TDATA_W = 240;
    localparam int TUSER_W = 3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        FT_TILE = 2'd0,
        FT_ELEV = 2'd1,
        FT_META = 2'd2,
        FT_ERR  = 2'd3
    } frame_t;

    typedef enum logic [2:0] {
        KIND_TILE    = 3'd0,
        KIND_ELEV    = 3'd1,
        KIND_META    = 3'd2,
        KIND_ERR     = 3'd3,
        KIND_PAYLOAD = 3'd4,
        KIND_SKIP    = 3'd5
    } kind_t;

    // One registered input byte
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } rsd_beat_t;

    // One result item
    typedef struct packed {
        kind_t       kind;
        logic [63:0] word_a;
        logic [63:0] word_b;
        logic [63:0] word_c;
        logic [31:0] payload_length;
        logic [7:0]  data_byte;
        logic [1:0]  payload_owner;
        logic        payload_last;
    } rsd_result_t;

    function automatic logic [4:0] header_len(frame_t ft);
        logic [4:0] len;
        unique case (ft)
            FT_TILE: len = HDR_LEN_TILE;
            FT_ELEV: len = HDR_LEN_ELEV;
            FT_META: len = HDR_LEN_META;
            default: len = HDR_LEN_ERR;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/rsd_in_stage.sv =====
module rsd_in_stage
    import rsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       pop,
    output rsd_beat_t  beat
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Room when empty or when the held byte leaves this cycle
    assign s_axis_tready = !in_valid_reg || pop;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Byte holding register
    always_ff @(posedge clk) begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    assign beat.valid = in_valid_reg;
    assign beat.data  = in_byte_reg;

endmodule

// ===== rtl/rsd_parser.sv =====
`include "response_stream_deframer_macros.svh"

module rsd_parser
    import rsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  in_byte,
    output logic        res_valid,
    output rsd_result_t res
);

    phase_t      phase_reg, phase_next;
    frame_t      ft_reg, ft_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] c_reg, c_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] remain_reg, remain_next;

    logic [4:0]  cnt_inc;
    logic [31:0] hdr_len_out;

    // State registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            ft_reg     <= FT_TILE;
            cnt_reg    <= '0;
            a_reg      <= '0;
            b_reg      <= '0;
            c_reg      <= '0;
            len_reg    <= '0;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            ft_reg     <= ft_next;
            cnt_reg    <= cnt_next;
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
        end
    end

    assign cnt_inc = cnt_reg + 5'd1;

    // Next state and result for one byte
    always_comb begin
        phase_next  = phase_reg;
        ft_next     = ft_reg;
        cnt_next    = cnt_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        hdr_len_out = '0;
        res_valid   = 1'b0;
        res         = '0;

        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    // Route the byte into its big-endian field
                    unique case (ft_reg)
                        FT_TILE:
                        begin
                            if (cnt_reg < 5'd4)       a_next = {a_reg[55:0], in_byte};
                            else if (cnt_reg < 5'd8)  b_next = {b_reg[55:0], in_byte};
                            else if (cnt_reg < 5'd12) c_next = {c_reg[55:0], in_byte};
                            else                      len_next = {len_reg[23:0], in_byte};
                        end
                        FT_ELEV:
                        begin
                            if (cnt_reg < 5'd8)       a_next = {a_reg[55:0], in_byte};
                            else if (cnt_reg < 5'd16) b_next = {b_reg[55:0], in_byte};
                            else                      c_next = {c_reg[55:0], in_byte};
                        end
                        FT_META:
                        begin
                            len_next = {len_reg[23:0], in_byte};
                        end
                        default:
                        begin
                            if (cnt_reg == 5'd0) a_next = {a_reg[55:0], in_byte};
                            else                 len_next = {len_reg[23:0], in_byte};
                        end
                    endcase

                    if (cnt_inc == header_len(ft_reg))
                    begin
                        // Header complete: emit it and arm the payload count
                        hdr_len_out        = (ft_reg == FT_ELEV) ? 32'd0 : len_next;
                        res_valid          = 1'b1;
                        res.kind           = kind_t'({1'b0, ft_reg});
                        res.word_a         = a_next;
                        res.word_b         = b_next;
                        res.word_c         = c_next;
                        res.payload_length = hdr_len_out;
                        remain_next        = hdr_len_out;
                        cnt_next           = '0;
                        phase_next         = (hdr_len_out != 32'd0) ? PH_PAYLOAD : PH_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid         = 1'b1;
                    res.kind          = KIND_PAYLOAD;
                    res.data_byte     = in_byte;
                    res.payload_owner = ft_reg;
                    if (remain_reg <= 32'd1)
                    begin
                        res.payload_last = 1'b1;
                        remain_next      = '0;
                        phase_next       = PH_IDLE;
                    end
                    else
                    begin
                        remain_next = remain_reg - 32'd1;
                    end
                end
                default:
                begin
                    // Idle: look for a type byte, skip anything else
                    phase_next = PH_IDLE;
                    if (in_byte == TYPE_TILE || in_byte == TYPE_ELEV ||
                        in_byte == TYPE_META || in_byte == TYPE_ERR)
                    begin
                        unique case (in_byte)
                            TYPE_TILE: ft_next = FT_TILE;
                            TYPE_ELEV: ft_next = FT_ELEV;
                            TYPE_META: ft_next = FT_META;
                            default:   ft_next = FT_ERR;
                        endcase
                        cnt_next    = '0;
                        a_next      = '0;
                        b_next      = '0;
                        c_next      = '0;
                        len_next    = '0;
                        remain_next = '0;
                        phase_next  = PH_HEADER;
                    end
                    else
                    begin
                        res_valid     = 1'b1;
                        res.kind      = KIND_SKIP;
                        res.data_byte = in_byte;
                    end
                end
            endcase
        end
    end

    // Checks
    `RSD_ASSERT_NOW(a_payload_count, clk, rst_n,
        phase_reg == PH_PAYLOAD, remain_reg != 32'd0,
        "payload phase with nothing left to pass")
    `RSD_ASSERT_NOW(a_header_count, clk, rst_n,
        phase_reg == PH_HEADER, cnt_reg < header_len(ft_reg),
        "header byte count beyond header length")
    `RSD_ASSERT_NEXT(a_last_to_idle, clk, rst_n,
        step && res_valid && res.payload_last, phase_reg == PH_IDLE,
        "last payload byte did not return to idle")

endmodule

// ===== rtl/rsd_out_stage.sv =====
module rsd_out_stage
    import rsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  rsd_result_t        res,
    output logic               busy,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [63:0] word_a, [127:64] word_b, [191:128] word_c, [223:192] payload_length,
    // [231:224] data_byte, [233:232] payload_owner, [239:234] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,  // [2:0] kind
    output logic               m_axis_tlast   // payload_last
);

    logic        out_valid_reg;
    rsd_result_t out_reg;

    // Holding a beat the receiver has not taken
    assign busy = out_valid_reg && !m_axis_tready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk) begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.payload_owner, out_reg.data_byte,
                            out_reg.payload_length, out_reg.word_c,
                            out_reg.word_b, out_reg.word_a};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.payload_last;

endmodule

// ===== rtl/response_stream_deframer.sv =====
// Response stream deframer.
// Input: byte stream on s_axis (one response byte per beat). A type byte
// 0x81/0x82/0x83/0xFF opens a tile, elevation, metadata or error frame; its
// big-endian header fields are gathered and one header beat is sent on
// m_axis. The announced payload bytes then go out one per beat, kind 4,
// with tlast on the final one. Bytes outside a frame that are not a type
// code go out as kind 5 and are otherwise dropped.
// Throughput: one byte per cycle unless m_axis stalls; no bubbles between frames.
// Path: a byte accepted into the input register is parsed into the output
// register once the output side has room, and is visible on m_axis from there.
// Type bytes and header bytes before the last produce no output beat.
// Stall: when m_axis_tready is low with a beat waiting, the parser holds and
// s_axis_tready drops once the input register is full; nothing is lost.
// Reset (rst_n low, async): both stages empty, parser idle, all
// accumulators and counts cleared.
`include "response_stream_deframer_macros.svh"

module response_stream_deframer
    import rsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] in_byte
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [63:0] word_a, [127:64] word_b, [191:128] word_c, [223:192] payload_length,
    // [231:224] data_byte, [233:232] payload_owner, [239:234] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser,   // [2:0] kind
    output logic               m_axis_tlast    // payload_last
);

    rsd_beat_t   beat;
    rsd_result_t res;
    logic        res_valid;
    logic        out_busy;
    logic        advance;

    // Parse the held byte whenever the output side has room
    assign advance = beat.valid && !out_busy;

    rsd_in_stage u_in (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .pop           (advance),
        .beat          (beat)
    );

    rsd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_byte   (beat.data),
        .res_valid (res_valid),
        .res       (res)
    );

    rsd_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance && res_valid),
        .res           (res),
        .busy          (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Checks
    `RSD_ASSERT_NOW(a_ready_when_full, clk, rst_n,
        !s_axis_tready, beat.valid && out_busy,
        "input stalled without a full pipeline")

endmodule

// ===== tb/tb_response_stream_deframer.sv =====
module tb_response_stream_deframer;
    import rsd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1240;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 20;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [TUSER_W-1:0] m_axis_tuser;
    logic               m_axis_tlast;

    response_stream_deframer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Stream bytes waiting to be sent, and beats the deframer should produce
    logic [7:0]  pending_bytes[$];
    rsd_result_t expected_beats[$];

    int  mismatch_count = 0;
    int  in_count       = 0;
    int  cycle_count    = 0;
    bit  in_done        = 1'b0;
    int  in_gap         = 0;
    int  out_gap        = 0;
    int  hold_left      = 0;
    bit  long_hold_done = 1'b0;

    // Predictor state
    phase_t      pr_phase = PH_IDLE;
    frame_t      pr_frame = FT_TILE;
    logic [4:0]  pr_seen  = '0;
    logic [63:0] acc_a    = '0;
    logic [63:0] acc_b    = '0;
    logic [63:0] acc_c    = '0;
    logic [31:0] acc_len  = '0;
    logic [31:0] pay_left = '0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Header byte count after the type byte
    function automatic logic [4:0] hdr_bytes(frame_t ft);
        case (ft)
            FT_TILE: return HDR_LEN_TILE;
            FT_ELEV: return HDR_LEN_ELEV;
            FT_META: return HDR_LEN_META;
            default: return HDR_LEN_ERR;
        endcase
    endfunction

    // Idle bursts stop near the end and pause every third stretch
    function automatic bit bursts_allowed();
        return (pending_bytes.size() > 150) && (((in_count / 160) % 3) != 2);
    endfunction

    // Advance the predicted deframer by one byte, queue any beat it yields
    task automatic deframe_byte(input logic [7:0] b);
        rsd_result_t res;
        logic [4:0]  idx;
        res = '0;
        if (pr_phase == PH_HEADER)
        begin
            idx = pr_seen;
            case (pr_frame)
                FT_TILE:
                begin
                    if (idx < 4)       acc_a = {acc_a[55:0], b};
                    else if (idx < 8)  acc_b = {acc_b[55:0], b};
                    else if (idx < 12) acc_c = {acc_c[55:0], b};
                    else               acc_len = {acc_len[23:0], b};
                end
                FT_ELEV:
                begin
                    if (idx < 8)       acc_a = {acc_a[55:0], b};
                    else if (idx < 16) acc_b = {acc_b[55:0], b};
                    else               acc_c = {acc_c[55:0], b};
                end
                FT_META: acc_len = {acc_len[23:0], b};
                default:
                begin
                    if (idx == 0) acc_a = {acc_a[55:0], b};
                    else          acc_len = {acc_len[23:0], b};
                end
            endcase
            pr_seen = pr_seen + 5'd1;
            if (pr_seen >= hdr_bytes(pr_frame))
            begin
                res.kind   = kind_t'({1'b0, pr_frame});
                res.word_a = acc_a;
                res.word_b = acc_b;
                res.word_c = acc_c;
                if (pr_frame != FT_ELEV)
                begin
                    res.payload_length = acc_len;
                    pay_left = acc_len;
                end
                else
                    pay_left = '0;
                pr_seen  = '0;
                pr_phase = (pay_left != 0) ? PH_PAYLOAD : PH_IDLE;
                expected_beats.push_back(res);
            end
        end
        else if (pr_phase == PH_PAYLOAD)
        begin
            res.kind          = KIND_PAYLOAD;
            res.data_byte     = b;
            res.payload_owner = pr_frame;
            if (pay_left <= 1)
            begin
                res.payload_last = 1'b1;
                pay_left = '0;
                pr_phase = PH_IDLE;
            end
            else
                pay_left = pay_left - 32'd1;
            expected_beats.push_back(res);
        end
        else
        begin
            // idle: a type code opens a frame, anything else is skipped
            case (b)
                TYPE_TILE, TYPE_ELEV, TYPE_META, TYPE_ERR:
                begin
                    pr_frame = (b == TYPE_TILE) ? FT_TILE :
                               (b == TYPE_ELEV) ? FT_ELEV :
                               (b == TYPE_META) ? FT_META : FT_ERR;
                    pr_seen  = '0;
                    acc_a    = '0;
                    acc_b    = '0;
                    acc_c    = '0;
                    acc_len  = '0;
                    pay_left = '0;
                    pr_phase = PH_HEADER;
                end
                default:
                begin
                    res.kind      = KIND_SKIP;
                    res.data_byte = b;
                    expected_beats.push_back(res);
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h (beat after %0d bytes in)",
                 what, got, want, in_count);
        mismatch_count++;
    endtask

    // Stimulus builders
    task automatic push_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            pending_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic add_header(input frame_t ft, input logic [63:0] a, input logic [63:0] b,
                              input logic [63:0] c, input logic [31:0] len);
        case (ft)
            FT_TILE:
            begin
                pending_bytes.push_back(TYPE_TILE);
                push_be(a, 4);
                push_be(b, 4);
                push_be(c, 4);
                push_be(len, 4);
            end
            FT_ELEV:
            begin
                pending_bytes.push_back(TYPE_ELEV);
                push_be(a, 8);
                push_be(b, 8);
                push_be(c, 8);
            end
            FT_META:
            begin
                pending_bytes.push_back(TYPE_META);
                push_be(len, 4);
            end
            default:
            begin
                pending_bytes.push_back(TYPE_ERR);
                push_be(a, 1);
                push_be(len, 4);
            end
        endcase
    endtask

    task automatic add_payload(input int n);
        for (int i = 0; i < n; i++)
            pending_bytes.push_back(8'($urandom));
    endtask

    // Any byte that is not a type code
    function automatic logic [7:0] noise_byte();
        logic [7:0] v;
        v = 8'($urandom);
        while (v == TYPE_TILE || v == TYPE_ELEV || v == TYPE_META || v == TYPE_ERR)
            v = 8'($urandom);
        return v;
    endfunction

    function automatic logic [31:0] rand_len();
        case ($urandom_range(0, 9))
            0, 1:    return 32'd0;
            8:       return 32'($urandom_range(9, 40));
            9:       return 32'd1;
            default: return 32'($urandom_range(1, 8));
        endcase
    endfunction

    // Input acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            deframe_byte(s_axis_tdata);
            void'(pending_bytes.pop_front());
            in_count++;
            in_done = 1'b1;
        end
    end

    // Output beat checker
    always @(posedge clk)
    begin : out_mon
        rsd_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat, kind", 64'(m_axis_tuser), '0);
            else
            begin
                want = expected_beats.pop_front();
                if (m_axis_tuser[2:0] != want.kind)
                    report_mismatch("kind", 64'(m_axis_tuser[2:0]), 64'(want.kind));
                if (m_axis_tdata[63:0] != want.word_a)
                    report_mismatch("word_a", m_axis_tdata[63:0], want.word_a);
                if (m_axis_tdata[127:64] != want.word_b)
                    report_mismatch("word_b", m_axis_tdata[127:64], want.word_b);
                if (m_axis_tdata[191:128] != want.word_c)
                    report_mismatch("word_c", m_axis_tdata[191:128], want.word_c);
                if (m_axis_tdata[223:192] != want.payload_length)
                    report_mismatch("payload_length", 64'(m_axis_tdata[223:192]),
                                    64'(want.payload_length));
                if (m_axis_tdata[231:224] != want.data_byte)
                    report_mismatch("data_byte", 64'(m_axis_tdata[231:224]),
                                    64'(want.data_byte));
                if (m_axis_tdata[233:232] != want.payload_owner)
                    report_mismatch("payload_owner", 64'(m_axis_tdata[233:232]),
                                    64'(want.payload_owner));
                if (m_axis_tlast != want.payload_last)
                    report_mismatch("payload_last", 64'(m_axis_tlast), 64'(want.payload_last));
                if (m_axis_tdata[239:234] != '0)
                    report_mismatch("pad bits", 64'(m_axis_tdata[239:234]), '0);
            end
        end
    end

    // Byte driver: holds a beat until taken, inserts idle bursts between beats
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && !in_done)
            begin
                // beat still on offer
            end
            else
            begin
                in_done = 1'b0;
                if (in_gap > 0)
                begin
                    in_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (bursts_allowed() && $urandom_range(0, 7) == 0)
                begin
                    in_gap = $urandom_range(0, 13);
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_bytes[0];
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off to back up the pipe, then random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!long_hold_done && in_count >= 80)
            begin
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (bursts_allowed() && $urandom_range(0, 6) == 0)
            begin
                out_gap = $urandom_range(0, 13);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("response_stream_deframer regression: fail");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;

        // Directed: skipped bytes, field extremes, every frame type,
        // zero and one byte payloads, type codes inside a payload
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h7E);
        add_header(FT_TILE, '0, '0, '0, 32'd0);
        add_header(FT_TILE, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'hFFFF_FFFF, 32'd1);
        add_payload(1);
        add_header(FT_ELEV, '0, '0, '0, '0);
        add_header(FT_ELEV, '1, '1, '1, '0);
        add_header(FT_ELEV, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                   64'h8000_0000_0000_0001, '0);
        add_header(FT_META, '0, '0, '0, 32'd0);
        add_header(FT_META, '0, '0, '0, 32'd3);
        pending_bytes.push_back(TYPE_TILE);
        pending_bytes.push_back(TYPE_ERR);
        pending_bytes.push_back(8'h00);
        add_header(FT_ERR, 64'hFF, '0, '0, 32'd2);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(TYPE_META);
        add_header(FT_ERR, 64'h00, '0, '0, 32'd0);
        pending_bytes.push_back(8'hFE);
        add_header(FT_TILE, 64'h1234_5678, 64'h8000_0001, 64'h0F0F_F0F0, 32'h0000_0102);
        add_payload(258);
        pending_bytes.push_back(8'h84);

        // Random: mostly well-formed frames, some runs of skipped bytes
        while (pending_bytes.size() < RANDOM_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 3))
                    pending_bytes.push_back(noise_byte());
            end
            else
            begin : rand_frame
                frame_t      ft;
                logic [31:0] len;
                ft  = frame_t'($urandom_range(0, 3));
                len = rand_len();
                add_header(ft, {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, len);
                if (ft != FT_ELEV)
                    add_payload(len);
            end
        end

        // Longest announced payload closes the run; only its head is sent
        add_header(FT_ERR, 64'($urandom_range(0, 255)), '0, '0, 32'hFFFF_FFFF);
        add_payload(10);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("response_stream_deframer regression: pass");
        else
            $display("response_stream_deframer regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rsd_pkg.sv
rtl/rsd_in_stage.sv
rtl/rsd_parser.sv
rtl/rsd_out_stage.sv
rtl/response_stream_deframer.sv
tb/tb_response_stream_deframer.sv
